[hw/rtl/tbpr_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tbpr_pkg
// Shared types, constants and helpers of the tile background pixel renderer.
// ----------------------------------------------------------------------------
package tbpr_pkg;

	localparam int VRAM_BYTES       = 8192;
	localparam int VRAM_AW          = $clog2(VRAM_BYTES);
	localparam int SCREEN_WIDTH_DEF = 160;
	localparam int QUEUE_DEPTH_DEF  = 4;
	localparam int PIXEL_INDEX_W    = 15;
	localparam int APB_AW           = 5;
	localparam int APB_DW           = 32;
	localparam int REG_IDX_W        = 3;

	localparam logic [REG_IDX_W-1:0] REG_SCROLL_X         = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_SCROLL_Y         = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_BG_PALETTE       = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_BG_ENABLE        = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_TILE_MAP_SELECT  = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_TILE_DATA_SELECT = 3'd5;

	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_RENDER = 1'b1;

	// tile maps live at offsets 0x1800 and 0x1C00
	localparam logic [1:0] MAP_BASE_HI = 2'b11;

	localparam logic [7:0] GREY_SHADE0 = 8'hFF;
	localparam logic [7:0] GREY_SHADE1 = 8'hAA;
	localparam logic [7:0] GREY_SHADE2 = 8'h55;
	localparam logic [7:0] GREY_SHADE3 = 8'h00;

	typedef struct packed {
		logic [7:0] scroll_x;
		logic [7:0] scroll_y;
		logic [7:0] bg_palette;
		logic       bg_enable;
		logic       tile_map_select;
		logic       tile_data_select;
	} tbpr_cfg_t;

	typedef struct packed {
		logic                     is_write;
		logic [VRAM_AW-1:0]       addr;
		logic [7:0]               data;
		logic [2:0]               x_fine;
		logic [2:0]               y_fine;
		logic [PIXEL_INDEX_W-1:0] pixel_index;
	} tbpr_entry_t;

	function automatic logic [7:0] grey_of_shade(input logic [1:0] s);
		logic [7:0] g;
		case (s)
			2'd0: g = GREY_SHADE0;
			2'd1: g = GREY_SHADE1;
			2'd2: g = GREY_SHADE2;
			default: g = GREY_SHADE3;
		endcase
		return g;
	endfunction

endpackage
`default_nettype wire

[hw/rtl/tbpr_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tbpr_front
// Accepts items, drops pixels while the background is off, forms the map
// address, fine offsets and frame index, and pushes the work to the queue.
// ----------------------------------------------------------------------------
module tbpr_front
	import tbpr_pkg::*;
#(
	parameter int SCREEN_WIDTH = SCREEN_WIDTH_DEF
) (
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic                     operation,
	input  wire logic [VRAM_AW-1:0]       vram_address,
	input  wire logic [7:0]               vram_byte,
	input  wire logic [7:0]               pixel_x,
	input  wire logic [7:0]               line_number,
	input  wire tbpr_cfg_t                cfg,
	input  wire logic                     q_full,
	output logic                          q_push,
	output tbpr_entry_t                   q_entry
);

	localparam logic [PIXEL_INDEX_W-1:0] SW = PIXEL_INDEX_W'(SCREEN_WIDTH);

	logic [7:0] xpos;
	logic [7:0] ypos;
	logic       is_write;

	assign xpos     = pixel_x + cfg.scroll_x;
	assign ypos     = line_number + cfg.scroll_y;
	assign is_write = (operation == OP_WRITE);

	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full && (is_write || cfg.bg_enable);

	always_comb begin
		q_entry.is_write    = is_write;
		q_entry.addr        = is_write ? vram_address
			: {MAP_BASE_HI, cfg.tile_map_select, ypos[7:3], xpos[7:3]};
		q_entry.data        = vram_byte;
		q_entry.x_fine      = xpos[2:0];
		q_entry.y_fine      = ypos[2:0];
		q_entry.pixel_index = PIXEL_INDEX_W'(pixel_x) + PIXEL_INDEX_W'(line_number) * SW;
	end

endmodule
`default_nettype wire

[hw/rtl/tbpr_fifo.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tbpr_fifo
// Short queue of classified items between the front and back.
// ----------------------------------------------------------------------------
module tbpr_fifo
	import tbpr_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire tbpr_entry_t entry_in,
	output logic             full,
	input  wire logic        pop,
	output tbpr_entry_t      entry_out,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

	tbpr_entry_t   entries_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full      = (count_q == FULL_COUNT);
	assign empty     = (count_q == '0);
	assign entry_out = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= entry_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

[hw/rtl/tbpr_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tbpr_back
// Video memory and the render sequencer: map read, tile row reads, palette
// lookup and the result register.
// ----------------------------------------------------------------------------
module tbpr_back
	import tbpr_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire tbpr_cfg_t                cfg,
	input  wire logic                     q_empty,
	input  wire tbpr_entry_t              q_entry,
	output logic                          q_pop,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic [PIXEL_INDEX_W-1:0]      pixel_index,
	output logic [7:0]                    brightness,
	output logic [1:0]                    shade
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_TILE,
		S_ROW
	} state_t;

	state_t                   state_q;
	logic [7:0]               vram_q [VRAM_BYTES];
	logic [7:0]               rd_a_q;
	logic [7:0]               rd_b_q;
	logic [2:0]               x_fine_q;
	logic [2:0]               y_fine_q;
	logic [PIXEL_INDEX_W-1:0] pidx_q;
	logic                     out_valid_q;
	logic [PIXEL_INDEX_W-1:0] pixel_index_q;
	logic [7:0]               brightness_q;
	logic [1:0]               shade_q;

	logic               mem_we;
	logic               map_rd;
	logic               rd_a_en;
	logic               rd_b_en;
	logic [VRAM_AW-1:0] rd_a_addr;
	logic [VRAM_AW-1:0] row_lo_addr;
	logic [VRAM_AW-1:0] row_hi_addr;
	logic               row_msb;
	logic [2:0]         bit_sel;
	logic [1:0]         colour;
	logic [1:0]         shade_c;
	logic               finish;

	assign q_pop  = (state_q == S_IDLE) && !q_empty;
	assign mem_we = q_pop && q_entry.is_write;
	assign map_rd = q_pop && !q_entry.is_write;

	// signed mode: base 0x9000 plus sign-extended tile * 16, modulo memory size
	assign row_msb     = cfg.tile_data_select ? 1'b0 : ~rd_a_q[7];
	assign row_lo_addr = {row_msb, rd_a_q, y_fine_q, 1'b0};
	assign row_hi_addr = {row_msb, rd_a_q, y_fine_q, 1'b1};

	assign rd_a_en   = map_rd || (state_q == S_TILE);
	assign rd_b_en   = (state_q == S_TILE);
	assign rd_a_addr = (state_q == S_TILE) ? row_lo_addr : q_entry.addr;

	assign bit_sel = 3'd7 - x_fine_q;
	assign colour  = {rd_b_q[bit_sel], rd_a_q[bit_sel]};
	assign shade_c = cfg.bg_palette[{colour, 1'b0} +: 2];
	assign finish  = (state_q == S_ROW) && (!out_valid_q || out_ready);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			vram_q[q_entry.addr] <= q_entry.data;
		end
		if (rd_a_en) begin
			rd_a_q <= vram_q[rd_a_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (rd_b_en) begin
			rd_b_q <= vram_q[row_hi_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (map_rd) begin
			x_fine_q <= q_entry.x_fine;
			y_fine_q <= q_entry.y_fine;
			pidx_q   <= q_entry.pixel_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			out_valid_q   <= 1'b0;
			pixel_index_q <= '0;
			brightness_q  <= '0;
			shade_q       <= '0;
		end else begin
			out_valid_q <= finish || (out_valid_q && !out_ready);
			case (state_q)
				S_IDLE: begin
					if (map_rd) begin
						state_q <= S_TILE;
					end
				end
				S_TILE: begin
					state_q <= S_ROW;
				end
				S_ROW: begin
					if (finish) begin
						state_q       <= S_IDLE;
						pixel_index_q <= pidx_q;
						shade_q       <= shade_c;
						brightness_q  <= grey_of_shade(shade_c);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_index = pixel_index_q;
	assign brightness  = brightness_q;
	assign shade       = shade_q;

	a_pop_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("queue popped while empty");

	a_row_after_tile: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TILE) |=> (state_q == S_ROW))
		else $error("row read did not follow tile read");

	a_result_from_row: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_ROW))
		else $error("result raised outside row stage");

	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !q_pop)
		else $error("queue popped while sequencer busy");

endmodule
`default_nettype wire

[hw/rtl/tile_background_pixel_renderer.sv]
`default_nettype none
// A pixel item is popped from the queue together with its tile map read; the back sequencer
//   then reads both tile row planes from the dual-read video memory and loads the result register.
//   It takes a new item only once the last is done; one memory write per cycle while it is idle.
// The input queue (QUEUE_DEPTH items) keeps taking items while the back end is busy or stalled, until full.
// Reset: configuration and output registers clear to 0 and the queue and result register empty; video memory is
//   not cleared and reads as undefined until written.
// ----------------------------------------------------------------------------
// tile_background_pixel_renderer
// Tile map background renderer, 2 bits per pixel, with APB register port.
// ----------------------------------------------------------------------------
module tile_background_pixel_renderer
	import tbpr_pkg::*;
#(
	parameter int SCREEN_WIDTH = SCREEN_WIDTH_DEF,
	parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     psel,
	input  wire logic                     penable,
	input  wire logic                     pwrite,
	input  wire logic [APB_AW-1:0]        paddr,
	input  wire logic [APB_DW-1:0]        pwdata,
	output logic [APB_DW-1:0]             prdata,
	output logic                          pready,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic                     operation,
	input  wire logic [VRAM_AW-1:0]       vram_address,
	input  wire logic [7:0]               vram_byte,
	input  wire logic [7:0]               pixel_x,
	input  wire logic [7:0]               line_number,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic [PIXEL_INDEX_W-1:0]      pixel_index,
	output logic [7:0]                    brightness,
	output logic [1:0]                    shade
);

	tbpr_cfg_t             cfg_q;
	logic [REG_IDX_W-1:0]  reg_idx;
	logic                  reg_wr;
	logic                  q_push;
	logic                  q_full;
	logic                  q_pop;
	logic                  q_empty;
	tbpr_entry_t           q_in;
	tbpr_entry_t           q_out;

	assign pready  = 1'b1;
	assign reg_idx = paddr[APB_AW-1:2];
	assign reg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (reg_wr) begin
			case (reg_idx)
				REG_SCROLL_X:         cfg_q.scroll_x         <= pwdata[7:0];
				REG_SCROLL_Y:         cfg_q.scroll_y         <= pwdata[7:0];
				REG_BG_PALETTE:       cfg_q.bg_palette       <= pwdata[7:0];
				REG_BG_ENABLE:        cfg_q.bg_enable        <= pwdata[0];
				REG_TILE_MAP_SELECT:  cfg_q.tile_map_select  <= pwdata[0];
				REG_TILE_DATA_SELECT: cfg_q.tile_data_select <= pwdata[0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_SCROLL_X:         prdata = {24'd0, cfg_q.scroll_x};
			REG_SCROLL_Y:         prdata = {24'd0, cfg_q.scroll_y};
			REG_BG_PALETTE:       prdata = {24'd0, cfg_q.bg_palette};
			REG_BG_ENABLE:        prdata = {31'd0, cfg_q.bg_enable};
			REG_TILE_MAP_SELECT:  prdata = {31'd0, cfg_q.tile_map_select};
			REG_TILE_DATA_SELECT: prdata = {31'd0, cfg_q.tile_data_select};
			default:              prdata = '0;
		endcase
	end

	tbpr_front #(
		.SCREEN_WIDTH(SCREEN_WIDTH)
	) u_front (
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.operation   (operation),
		.vram_address(vram_address),
		.vram_byte   (vram_byte),
		.pixel_x     (pixel_x),
		.line_number (line_number),
		.cfg         (cfg_q),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_entry     (q_in)
	);

	tbpr_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.entry_in (q_in),
		.full     (q_full),
		.pop      (q_pop),
		.entry_out(q_out),
		.empty    (q_empty)
	);

	tbpr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.q_empty    (q_empty),
		.q_entry    (q_out),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.pixel_index(pixel_index),
		.brightness (brightness),
		.shade      (shade)
	);

endmodule
`default_nettype wire
